// File: sv/pcdr_pkg.sv
// pcdr_pkg: shared types, event codes and register indexes for the
// pointer click/drag/repeat qualifier; no dependencies
package pcdr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DRAG_W     = 24;
  localparam int MAG_W      = 12;
  localparam int SQ_W       = 2 * MAG_W;

  localparam logic [15:0] DUP_WINDOW_RST   = 16'd100;
  localparam logic [15:0] HOLD_DELAY_RST   = 16'd400;
  localparam logic [15:0] REPEAT_INT_RST   = 16'd500;
  localparam logic [15:0] SHORT_PRESS_RST  = 16'd200;
  localparam logic [11:0] DRAG_THRESH_RST  = 12'd64;

  localparam logic [DRAG_W-1:0] DRAG_MAX = 24'h7FFFFF;
  localparam logic [DRAG_W-1:0] DRAG_MIN = 24'h800000;

  typedef enum logic [2:0] {
    MODE_OFFER     = 3'd0,
    MODE_LEFT_DN   = 3'd1,
    MODE_LEFT_UP   = 3'd2,
    MODE_WALK      = 3'd3,
    MODE_RIGHT_DN  = 3'd4,
    MODE_DRAG      = 3'd5,
    MODE_RIGHT_UP  = 3'd6
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUP_WINDOW  = 3'd0,
    REG_HOLD_DELAY  = 3'd1,
    REG_REPEAT_INT  = 3'd2,
    REG_SHORT_PRESS = 3'd3,
    REG_DRAG_THRESH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]   dup_window;
    logic [15:0]   hold_delay;
    logic [15:0]   repeat_int;
    logic [15:0]   short_press;
    logic [SQ_W-1:0] thresh_sq;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [1:0]  target_kind;
    logic [31:0] ground_x;
    logic [31:0] ground_y;
    logic [31:0] world_ident;
    logic [31:0] actor_handle;
    logic [31:0] action_ident;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [15:0] delta_x;
    logic [15:0] delta_y;
  } item_t;

  // per-item result before the drag length check
  typedef struct packed {
    logic             accepted;
    logic             walk_fire;
    logic             had_press;
    logic             short_ok;
    logic             drag_small;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [15:0]      restore_x;
    logic [15:0]      restore_y;
    logic             right_down;
  } core_res_t;

endpackage

// File: sv/pcdr_cfg.sv
// pcdr_cfg: configuration registers and the squared drag threshold
// depends on pcdr_pkg
module pcdr_cfg
  import pcdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [MAG_W-1:0] thr_w;
  assign thr_w = cfg_data[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dup_window  <= DUP_WINDOW_RST;
      cfg.hold_delay  <= HOLD_DELAY_RST;
      cfg.repeat_int  <= REPEAT_INT_RST;
      cfg.short_press <= SHORT_PRESS_RST;
      cfg.thresh_sq   <= SQ_W'(DRAG_THRESH_RST) * SQ_W'(DRAG_THRESH_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DUP_WINDOW:  cfg.dup_window  <= cfg_data;
        REG_HOLD_DELAY:  cfg.hold_delay  <= cfg_data;
        REG_REPEAT_INT:  cfg.repeat_int  <= cfg_data;
        REG_SHORT_PRESS: cfg.short_press <= cfg_data;
        // keep the square, the raw threshold is never needed
        REG_DRAG_THRESH: cfg.thresh_sq   <= SQ_W'(thr_w) * SQ_W'(thr_w);
        default: ;
      endcase
    end
  end

endmodule

// File: sv/pcdr_core.sv
// pcdr_core: event state (target, left hold, right press, drag sums)
// and the per-item decision logic; depends on pcdr_pkg
module pcdr_core
  import pcdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  item_t     item,
  input  cfg_t      cfg,
  output core_res_t res
);

  logic              last_valid, last_valid_next;
  logic [1:0]        last_kind, last_kind_next;
  logic [31:0]       last_gx, last_gx_next, last_gy, last_gy_next;
  logic [31:0]       last_world, last_world_next, last_handle, last_handle_next;
  logic [31:0]       last_action, last_action_next;
  logic [31:0]       last_accept_time, last_accept_time_next;
  logic              left_held, left_held_next;
  logic [31:0]       left_press_time, left_press_time_next;
  logic              sample_valid, sample_valid_next;
  logic [31:0]       sample_time, sample_time_next;
  logic              right_held, right_held_next;
  logic [15:0]       saved_x, saved_x_next, saved_y, saved_y_next;
  logic [31:0]       right_press_time, right_press_time_next;
  logic [DRAG_W-1:0] drag_x, drag_x_next, drag_y, drag_y_next;

  logic [31:0]       dt_accept, dt_press, dt_sample, dt_right;
  logic              same, dup;
  logic [DRAG_W-1:0] sum_x, sum_y, abs_x, abs_y;

  function automatic logic [DRAG_W-1:0] sat_add(input logic [DRAG_W-1:0] acc,
                                                input logic [15:0] d);
    logic [DRAG_W:0] s;
    s = {acc[DRAG_W-1], acc} + {{(DRAG_W-15){d[15]}}, d};
    if (s[DRAG_W] != s[DRAG_W-1]) return s[DRAG_W] ? DRAG_MIN : DRAG_MAX;
    return s[DRAG_W-1:0];
  endfunction

  assign dt_accept = item.now_ms - last_accept_time;
  assign dt_press  = item.now_ms - left_press_time;
  assign dt_sample = item.now_ms - sample_time;
  assign dt_right  = item.now_ms - right_press_time;

  assign same = last_valid && last_kind == item.target_kind &&
                last_gx == item.ground_x && last_gy == item.ground_y &&
                last_world == item.world_ident && last_handle == item.actor_handle &&
                last_action == item.action_ident;
  assign dup  = same && dt_accept <= {16'd0, cfg.dup_window};

  assign sum_x = sat_add(drag_x, item.delta_x);
  assign sum_y = sat_add(drag_y, item.delta_y);
  assign abs_x = drag_x[DRAG_W-1] ? (DRAG_W'(0) - drag_x) : drag_x;
  assign abs_y = drag_y[DRAG_W-1] ? (DRAG_W'(0) - drag_y) : drag_y;

  always_comb begin
    last_valid_next       = last_valid;
    last_kind_next        = last_kind;
    last_gx_next          = last_gx;
    last_gy_next          = last_gy;
    last_world_next       = last_world;
    last_handle_next      = last_handle;
    last_action_next      = last_action;
    last_accept_time_next = last_accept_time;
    left_held_next        = left_held;
    left_press_time_next  = left_press_time;
    sample_valid_next     = sample_valid;
    sample_time_next      = sample_time;
    right_held_next       = right_held;
    saved_x_next          = saved_x;
    saved_y_next          = saved_y;
    right_press_time_next = right_press_time;
    drag_x_next           = drag_x;
    drag_y_next           = drag_y;
    res                   = '0;

    unique case (item.mode)
      MODE_OFFER: begin
        if (!dup) begin
          last_valid_next       = 1'b1;
          last_kind_next        = item.target_kind;
          last_gx_next          = item.ground_x;
          last_gy_next          = item.ground_y;
          last_world_next       = item.world_ident;
          last_handle_next      = item.actor_handle;
          last_action_next      = item.action_ident;
          last_accept_time_next = item.now_ms;
          res.accepted          = 1'b1;
        end
      end
      MODE_LEFT_DN: begin
        left_held_next       = 1'b1;
        left_press_time_next = item.now_ms;
        sample_valid_next    = 1'b0;
      end
      MODE_LEFT_UP: begin
        left_held_next    = 1'b0;
        sample_valid_next = 1'b0;
      end
      MODE_WALK: begin
        if (left_held && dt_press > {16'd0, cfg.hold_delay} &&
            !(sample_valid && dt_sample < {16'd0, cfg.repeat_int})) begin
          sample_valid_next = 1'b1;
          sample_time_next  = item.now_ms;
          res.walk_fire     = 1'b1;
        end
      end
      MODE_RIGHT_DN: begin
        right_held_next       = 1'b1;
        saved_x_next          = item.cursor_x;
        saved_y_next          = item.cursor_y;
        right_press_time_next = item.now_ms;
        drag_x_next           = '0;
        drag_y_next           = '0;
      end
      MODE_DRAG: begin
        if (right_held) begin
          drag_x_next = sum_x;
          drag_y_next = sum_y;
        end
      end
      MODE_RIGHT_UP: begin
        if (right_held) begin
          res.had_press  = 1'b1;
          res.restore_x  = saved_x;
          res.restore_y  = saved_y;
          res.short_ok   = dt_right <= {16'd0, cfg.short_press};
          // beyond 12 bits the square alone exceeds any threshold square
          res.drag_small = abs_x[DRAG_W-1:MAG_W] == '0 && abs_y[DRAG_W-1:MAG_W] == '0;
          res.mag_x      = abs_x[MAG_W-1:0];
          res.mag_y      = abs_y[MAG_W-1:0];
          right_held_next = 1'b0;
          drag_x_next     = '0;
          drag_y_next     = '0;
        end
      end
      default: ;
    endcase
    res.right_down = right_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid       <= 1'b0;
      last_kind        <= '0;
      last_gx          <= '0;
      last_gy          <= '0;
      last_world       <= '0;
      last_handle      <= '0;
      last_action      <= '0;
      last_accept_time <= '0;
      left_held        <= 1'b0;
      left_press_time  <= '0;
      sample_valid     <= 1'b0;
      sample_time      <= '0;
      right_held       <= 1'b0;
      saved_x          <= '0;
      saved_y          <= '0;
      right_press_time <= '0;
      drag_x           <= '0;
      drag_y           <= '0;
    end else if (fire) begin
      last_valid       <= last_valid_next;
      last_kind        <= last_kind_next;
      last_gx          <= last_gx_next;
      last_gy          <= last_gy_next;
      last_world       <= last_world_next;
      last_handle      <= last_handle_next;
      last_action      <= last_action_next;
      last_accept_time <= last_accept_time_next;
      left_held        <= left_held_next;
      left_press_time  <= left_press_time_next;
      sample_valid     <= sample_valid_next;
      sample_time      <= sample_time_next;
      right_held       <= right_held_next;
      saved_x          <= saved_x_next;
      saved_y          <= saved_y_next;
      right_press_time <= right_press_time_next;
      drag_x           <= drag_x_next;
      drag_y           <= drag_y_next;
    end
  end

endmodule

// File: sv/pcdr_cancel.sv
// pcdr_cancel: registered squares of the drag magnitudes and the
// compare against the squared threshold; depends on pcdr_pkg
module pcdr_cancel
  import pcdr_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [MAG_W-1:0] mag_x,
  input  logic [MAG_W-1:0] mag_y,
  input  logic [SQ_W-1:0]  thresh_sq,
  output logic             below
);

  logic [SQ_W-1:0] sq_x, sq_y;
  logic [SQ_W:0]   len_sq;

  always_ff @(posedge clk) begin
    if (load) begin
      sq_x <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sq_y <= SQ_W'(mag_y) * SQ_W'(mag_y);
    end
  end

  assign len_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign below  = len_sq < {1'b0, thresh_sq};

endmodule

// File: sv/pointer_click_drag_repeat_qualifier.sv
// pointer_click_drag_repeat_qualifier: top level, input register, pipeline
// control and result register; uses pcdr_pkg, pcdr_cfg, pcdr_core, pcdr_cancel
// registers: input, decision, squares and result; one result per item
// throughput: one item per cycle while out_ready does not stall the pipeline
// reset: synchronous rst clears all valid bits and event state, registers
// return to their defaults
module pointer_click_drag_repeat_qualifier
  import pcdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            mode,
  input  logic [31:0]           now_ms,
  input  logic [1:0]            target_kind,
  input  logic signed [31:0]    ground_x,
  input  logic signed [31:0]    ground_y,
  input  logic [31:0]           world_ident,
  input  logic [31:0]           actor_handle,
  input  logic [31:0]           action_ident,
  input  logic signed [15:0]    cursor_x,
  input  logic signed [15:0]    cursor_y,
  input  logic signed [15:0]    delta_x,
  input  logic signed [15:0]    delta_y,
  // result item channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  accepted,
  output logic                  walk_fire,
  output logic                  had_press,
  output logic                  cancel_intent,
  output logic signed [15:0]    restore_x,
  output logic signed [15:0]    restore_y,
  output logic                  right_down
);

  cfg_t      cfg;
  item_t     s0_item;
  core_res_t core_res, s1_res, s2_res;
  logic      s0_valid, s1_valid, s2_valid;
  logic      en0, en1, en2, en3;
  logic      below;

  // each stage loads when it is empty or its contents move on
  assign en3      = !out_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign en0      = !s0_valid || en1;
  assign in_ready = en0;

  pcdr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en0) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      s0_item.mode         <= mode;
      s0_item.now_ms       <= now_ms;
      s0_item.target_kind  <= target_kind;
      s0_item.ground_x     <= ground_x;
      s0_item.ground_y     <= ground_y;
      s0_item.world_ident  <= world_ident;
      s0_item.actor_handle <= actor_handle;
      s0_item.action_ident <= action_ident;
      s0_item.cursor_x     <= cursor_x;
      s0_item.cursor_y     <= cursor_y;
      s0_item.delta_x      <= delta_x;
      s0_item.delta_y      <= delta_y;
    end
  end

  // event state advances exactly when an item leaves stage 0
  pcdr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (s0_valid && en1),
    .item (s0_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  // stage 1: decision result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s0_valid) s1_res <= core_res;
  end

  // stage 2: squares of the drag magnitudes registered alongside
  pcdr_cancel u_cancel (
    .clk       (clk),
    .load      (en2 && s1_valid),
    .mag_x     (s1_res.mag_x),
    .mag_y     (s1_res.mag_y),
    .thresh_sq (cfg.thresh_sq),
    .below     (below)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) s2_res <= s1_res;
  end

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_valid) begin
      accepted      <= s2_res.accepted;
      walk_fire     <= s2_res.walk_fire;
      had_press     <= s2_res.had_press;
      // short press and a drag that stayed inside the threshold circle
      cancel_intent <= s2_res.had_press && s2_res.short_ok && s2_res.drag_small && below;
      restore_x     <= s2_res.restore_x;
      restore_y     <= s2_res.restore_y;
      right_down    <= s2_res.right_down;
    end
  end

  // a cancel only ever comes with a matched right press
  a_cancel_needs_press: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!cancel_intent || had_press))
    else $error("cancel_intent without had_press");

  // one event kind per item, so at most one qualifier flag
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({accepted, walk_fire, had_press}))
    else $error("more than one qualifier flag set");

  // restore cursor is zero unless a press was matched
  a_restore_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !had_press) |-> (restore_x == 16'sd0 && restore_y == 16'sd0))
    else $error("restore cursor set without press");

  // a matched right release always leaves the button up
  a_release_up: assert property (@(posedge clk) disable iff (rst)
    (out_valid && had_press) |-> !right_down)
    else $error("right_down after matched release");

endmodule
